// ----- design/vtl_pkg.sv -----
// Shared types, widths and constants of the vertex transform and lighting block.
package vtl_pkg;

	localparam int COEF_W = 16;
	localparam int POS_W = 24;
	localparam int COLOR_W = 8;
	localparam int FRAC_BITS = 12;

	localparam int CLIP_W = 43;
	localparam int CMAG_W = CLIP_W - 1;
	localparam int NRM_W = 35;
	localparam int NMAG_W = NRM_W - 1;
	localparam int RED_W = 17;
	localparam int SUM_W = 36;
	localparam int SQ_IN_W = 64;
	localparam int SQ_OUT_W = 32;
	localparam int CDIV_W = 32;
	localparam int CPROD_W = COLOR_W + CDIV_W;

	localparam int SQRT_STAGES = SQ_IN_W / 2;
	localparam int LIGHT_DEPTH = 17 + SQRT_STAGES;
	localparam int POS_DEPTH = 5 + POS_W;
	localparam int POS_PAD = LIGHT_DEPTH - POS_DEPTH;

	localparam logic signed [POS_W-1:0] NDC_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] NDC_MIN = {1'b1, {(POS_W-1){1'b0}}};
	localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_BITS);

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef coef_t [3:0][3:0] clip_mat_t;
	typedef coef_t [2:0][2:0] norm_mat_t;

	typedef struct packed {
		logic enable;
		coef_t [2:0] dir;
	} light_cfg_t;

	localparam clip_mat_t CLIP_RESET = {COEF_ONE, 48'd0, 16'd0, COEF_ONE, 32'd0,
		32'd0, COEF_ONE, 16'd0, 48'd0, COEF_ONE};
	localparam norm_mat_t NORM_RESET = {COEF_ONE, 32'd0, 16'd0, COEF_ONE, 16'd0,
		32'd0, COEF_ONE};
	localparam light_cfg_t LIGHT_RESET = {1'b0, COEF_ONE, 32'd0};

	typedef enum logic [2:0] {
		REG_CLIP_0,
		REG_CLIP_1,
		REG_CLIP_2,
		REG_CLIP_3,
		REG_NORM_0,
		REG_NORM_1,
		REG_NORM_2,
		REG_LIGHT
	} cfg_reg_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic signed [COEF_W-1:0] norm_x;
		logic signed [COEF_W-1:0] norm_y;
		logic signed [COEF_W-1:0] norm_z;
		logic [COLOR_W-1:0] base_red;
		logic [COLOR_W-1:0] base_green;
		logic [COLOR_W-1:0] base_blue;
	} vertex_in_t;

	typedef struct packed {
		logic signed [POS_W-1:0] ndc_x;
		logic signed [POS_W-1:0] ndc_y;
		logic signed [POS_W-1:0] ndc_z;
		logic [COLOR_W-1:0] lit_red;
		logic [COLOR_W-1:0] lit_green;
		logic [COLOR_W-1:0] lit_blue;
		logic zero_w;
	} vertex_out_t;

	typedef struct packed {
		logic signed [POS_W-1:0] ndc_x;
		logic signed [POS_W-1:0] ndc_y;
		logic signed [POS_W-1:0] ndc_z;
		logic zero_w;
	} pos_result_t;

endpackage

// ----- design/vtl_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module vtl_isqrt import vtl_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [SQ_IN_W-1:0]  x_in,
	output logic [SQ_OUT_W-1:0] root
);

	logic [SQ_IN_W-1:0] rem_s [1:SQRT_STAGES];
	logic [SQ_IN_W-1:0] res_s [1:SQRT_STAGES];
	logic [SQ_IN_W-1:0] rem_nx [SQRT_STAGES];
	logic [SQ_IN_W-1:0] res_nx [SQRT_STAGES];

	always_comb begin
		logic [SQ_IN_W:0] trial;
		logic [SQ_IN_W-1:0] bitv;
		logic [SQ_IN_W-1:0] rem_in [SQRT_STAGES];
		logic [SQ_IN_W-1:0] res_in [SQRT_STAGES];
		rem_in[0] = x_in;
		res_in[0] = '0;
		for (int j = 1; j < SQRT_STAGES; j++) begin
			rem_in[j] = rem_s[j];
			res_in[j] = res_s[j];
		end
		for (int j = 0; j < SQRT_STAGES; j++) begin
			bitv = SQ_IN_W'(1) << (SQ_IN_W - 2 - 2 * j);
			trial = {1'b0, res_in[j]} + {1'b0, bitv};
			if ({1'b0, rem_in[j]} >= trial) begin
				rem_nx[j] = rem_in[j] - trial[SQ_IN_W-1:0];
				res_nx[j] = (res_in[j] >> 1) + bitv;
			end else begin
				rem_nx[j] = rem_in[j];
				res_nx[j] = res_in[j] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < SQRT_STAGES; j++) begin
				rem_s[j+1] <= rem_nx[j];
				res_s[j+1] <= res_nx[j];
			end
		end
	end

	assign root = res_s[SQRT_STAGES][SQ_OUT_W-1:0];

endmodule

// ----- design/vtl_pos_path.sv -----
// Position path: clip transform, pipelined perspective divide and saturation.
module vtl_pos_path import vtl_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  clip_mat_t   clip_mat,
	input  vertex_in_t  vin,
	output pos_result_t result
);

	localparam int R_W = CMAG_W + 1;
	localparam int PROD_W = COEF_W + POS_W;

	typedef struct packed {
		logic [2:0][R_W-1:0] r;
		logic [2:0][POS_W-1:0] d;
		logic [2:0][POS_W-1:0] q;
		logic [CMAG_W-1:0] b;
		logic [2:0] ovf;
		logic [2:0] neg;
		logic [2:0] cpos;
		logic [2:0] cneg;
		logic zw;
	} pdiv_t;

	function automatic pdiv_t pdiv_step(pdiv_t x);
		pdiv_t y;
		logic [R_W-1:0] t;
		y = x;
		for (int i = 0; i < 3; i++) begin
			t = {x.r[i][R_W-2:0], x.d[i][POS_W-1]};
			y.d[i] = {x.d[i][POS_W-2:0], 1'b0};
			if (t >= R_W'(x.b)) begin
				y.r[i] = t - R_W'(x.b);
				y.q[i] = {x.q[i][POS_W-2:0], 1'b1};
			end else begin
				y.r[i] = t;
				y.q[i] = {x.q[i][POS_W-2:0], 1'b0};
			end
		end
		return y;
	endfunction

	logic signed [POS_W-1:0] p [3];
	logic signed [PROD_W-1:0] prod_s1 [4][3];
	logic signed [CLIP_W-1:0] c_s2 [4];
	logic [CMAG_W-1:0] a_s3 [3];
	logic [CMAG_W-1:0] b_s3;
	logic [2:0] neg_s3, cpos_s3, cneg_s3;
	logic zw_s3;
	pdiv_t div_s [POS_W+1];
	pdiv_t div_init;
	pos_result_t fin_nx, fin_s;
	pos_result_t pad_s [POS_PAD];

	assign p[0] = vin.pos_x;
	assign p[1] = vin.pos_y;
	assign p[2] = vin.pos_z;

	always_comb begin
		div_init.b = b_s3;
		div_init.neg = neg_s3;
		div_init.cpos = cpos_s3;
		div_init.cneg = cneg_s3;
		div_init.zw = zw_s3;
		for (int i = 0; i < 3; i++) begin
			div_init.ovf[i] = {{FRAC_BITS{1'b0}}, a_s3[i]} >= {b_s3, {FRAC_BITS{1'b0}}};
			div_init.r[i] = R_W'(a_s3[i] >> FRAC_BITS);
			div_init.d[i] = {a_s3[i][FRAC_BITS-1:0], {(POS_W-FRAC_BITS){1'b0}}};
			div_init.q[i] = '0;
		end
	end

	always_comb begin
		logic [POS_W-1:0] q;
		logic signed [POS_W-1:0] v [3];
		for (int i = 0; i < 3; i++) begin
			q = div_s[POS_W].q[i];
			if (div_s[POS_W].zw) begin
				v[i] = div_s[POS_W].cpos[i] ? NDC_MAX : (div_s[POS_W].cneg[i] ? NDC_MIN : '0);
			end else if (div_s[POS_W].ovf[i]) begin
				v[i] = div_s[POS_W].neg[i] ? NDC_MIN : NDC_MAX;
			end else if (div_s[POS_W].neg[i]) begin
				v[i] = (q > POS_W'(NDC_MIN)) ? NDC_MIN : -$signed(q);
			end else begin
				v[i] = (q > POS_W'(NDC_MAX)) ? NDC_MAX : $signed(q);
			end
		end
		fin_nx.ndc_x = v[0];
		fin_nx.ndc_y = v[1];
		fin_nx.ndc_z = v[2];
		fin_nx.zero_w = div_s[POS_W].zw;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s1[r][k] <= $signed(clip_mat[r][k]) * $signed(p[k]);
				end
				c_s2[r] <= CLIP_W'(prod_s1[r][0]) + CLIP_W'(prod_s1[r][1])
					+ CLIP_W'(prod_s1[r][2])
					+ (CLIP_W'($signed(clip_mat[r][3])) <<< FRAC_BITS);
			end
			zw_s3 <= c_s2[3] == '0;
			b_s3 <= c_s2[3][CLIP_W-1] ? CMAG_W'(-c_s2[3]) : CMAG_W'(c_s2[3]);
			for (int i = 0; i < 3; i++) begin
				a_s3[i] <= c_s2[i][CLIP_W-1] ? CMAG_W'(-c_s2[i]) : CMAG_W'(c_s2[i]);
				neg_s3[i] <= c_s2[i][CLIP_W-1] ^ c_s2[3][CLIP_W-1];
				cneg_s3[i] <= c_s2[i][CLIP_W-1];
				cpos_s3[i] <= !c_s2[i][CLIP_W-1] && (c_s2[i] != '0);
			end
			div_s[0] <= div_init;
			for (int j = 1; j <= POS_W; j++) begin
				div_s[j] <= pdiv_step(div_s[j-1]);
			end
			fin_s <= fin_nx;
			pad_s[0] <= fin_s;
			for (int j = 1; j < POS_PAD; j++) begin
				pad_s[j] <= pad_s[j-1];
			end
		end
	end

	assign result = pad_s[POS_PAD-1];

endmodule

// ----- design/vtl_light_path.sv -----
// Lighting path: normal transform, vector reduction, cosine and colour scaling.
module vtl_light_path import vtl_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  norm_mat_t                norm_mat,
	input  light_cfg_t               light,
	input  vertex_in_t               vin,
	output logic [2:0][COLOR_W-1:0]  lit
);

	localparam int NPROD_W = 2 * COEF_W;
	localparam int RPROD_W = 2 * RED_W;
	localparam int SHIFT_W = 5;

	typedef struct packed {
		logic [CDIV_W-1:0] d;
		logic dark;
		logic [2:0][COLOR_W-1:0] base;
	} side_t;

	typedef struct packed {
		logic [2:0][CDIV_W-1:0] r;
		logic [2:0][COLOR_W-1:0] x_lo;
		logic [2:0][COLOR_W-1:0] q;
		logic [2:0][COLOR_W-1:0] base;
		logic [SQ_OUT_W-1:0] s;
		logic dark;
	} cdiv_t;

	function automatic cdiv_t cdiv_step(cdiv_t x);
		cdiv_t y;
		logic [CDIV_W:0] t;
		y = x;
		for (int i = 0; i < 3; i++) begin
			t = {x.r[i], x.x_lo[i][COLOR_W-1]};
			y.x_lo[i] = {x.x_lo[i][COLOR_W-2:0], 1'b0};
			if (t >= {1'b0, x.s}) begin
				y.r[i] = CDIV_W'(t - {1'b0, x.s});
				y.q[i] = {x.q[i][COLOR_W-2:0], 1'b1};
			end else begin
				y.r[i] = t[CDIV_W-1:0];
				y.q[i] = {x.q[i][COLOR_W-2:0], 1'b0};
			end
		end
		return y;
	endfunction

	logic signed [COEF_W-1:0] nin [3];
	logic [2:0][COLOR_W-1:0] base_in;
	logic signed [RED_W-1:0] lr [3];

	logic signed [NPROD_W-1:0] nprod_s1 [3][3];
	logic [2:0][COLOR_W-1:0] base_s1, base_s2, base_s3, base_s4, base_s5, base_s6;
	logic signed [NRM_W-1:0] n_s2 [3];
	logic [NMAG_W-1:0] nm_s3 [3];
	logic [2:0] nneg_s3;
	logic [SHIFT_W-1:0] k_nx;
	logic signed [RED_W-1:0] nr_s4 [3];
	logic signed [RPROD_W-1:0] pd_s5 [3], pl_s5 [3], pn_s5 [3];
	logic signed [SUM_W-1:0] d_s6, l2_s6, n2_s6;
	logic [SQ_IN_W-1:0] sq_in_s7;
	side_t side_s [SQRT_STAGES+1];
	logic [SQ_OUT_W-1:0] root;
	logic [CPROD_W-1:0] cprod_s40 [3];
	logic [2:0][COLOR_W-1:0] base_s40;
	logic [SQ_OUT_W-1:0] s_s40;
	logic dark_s40;
	cdiv_t cdiv_init;
	cdiv_t cdiv_s [1:COLOR_W];
	logic [2:0][COLOR_W-1:0] lit_s;
	logic [2:0][COLOR_W-1:0] lit_nx;

	assign nin[0] = vin.norm_x;
	assign nin[1] = vin.norm_y;
	assign nin[2] = vin.norm_z;
	assign base_in[0] = vin.base_red;
	assign base_in[1] = vin.base_green;
	assign base_in[2] = vin.base_blue;

	always_comb begin
		logic signed [RED_W-1:0] dext;
		logic [RED_W-1:0] lm [3];
		logic big;
		big = 1'b0;
		for (int i = 0; i < 3; i++) begin
			dext = RED_W'($signed(light.dir[i]));
			lm[i] = dext[RED_W-1] ? RED_W'(-dext) : RED_W'(dext);
			big = big | lm[i][COEF_W-1];
		end
		for (int i = 0; i < 3; i++) begin
			dext = RED_W'($signed(light.dir[i]));
			lr[i] = dext[RED_W-1] ? -$signed(lm[i] >> big) : $signed(lm[i] >> big);
		end
	end

	always_comb begin
		logic [NMAG_W-1:0] mor;
		mor = nm_s3[0] | nm_s3[1] | nm_s3[2];
		k_nx = '0;
		for (int b = COEF_W - 1; b < NMAG_W; b++) begin
			if (mor[b]) begin
				k_nx = SHIFT_W'(b - (COEF_W - 2));
			end
		end
	end

	always_comb begin
		cdiv_init.s = s_s40;
		cdiv_init.dark = dark_s40;
		cdiv_init.base = base_s40;
		for (int i = 0; i < 3; i++) begin
			cdiv_init.r[i] = cprod_s40[i][CPROD_W-1:COLOR_W];
			cdiv_init.x_lo[i] = cprod_s40[i][COLOR_W-1:0];
			cdiv_init.q[i] = '0;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (!light.enable) begin
				lit_nx[i] = cdiv_s[COLOR_W].base[i];
			end else if (cdiv_s[COLOR_W].dark) begin
				lit_nx[i] = '0;
			end else if (cdiv_s[COLOR_W].q[i] > cdiv_s[COLOR_W].base[i]) begin
				lit_nx[i] = cdiv_s[COLOR_W].base[i];
			end else begin
				lit_nx[i] = cdiv_s[COLOR_W].q[i];
			end
		end
	end

	vtl_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.x_in (sq_in_s7),
		.root (root)
	);

	always_ff @(posedge clk) begin
		logic [NMAG_W-1:0] sh;
		if (en) begin
			base_s1 <= base_in;
			base_s2 <= base_s1;
			base_s3 <= base_s2;
			base_s4 <= base_s3;
			base_s5 <= base_s4;
			base_s6 <= base_s5;
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					nprod_s1[r][k] <= $signed(norm_mat[r][k]) * $signed(nin[k]);
				end
				n_s2[r] <= NRM_W'(nprod_s1[r][0]) + NRM_W'(nprod_s1[r][1])
					+ NRM_W'(nprod_s1[r][2]);
				nm_s3[r] <= n_s2[r][NRM_W-1] ? NMAG_W'(-n_s2[r]) : NMAG_W'(n_s2[r]);
				nneg_s3[r] <= n_s2[r][NRM_W-1];
				sh = nm_s3[r] >> k_nx;
				nr_s4[r] <= nneg_s3[r] ? -$signed(RED_W'(sh[COEF_W-2:0]))
					: $signed(RED_W'(sh[COEF_W-2:0]));
				pd_s5[r] <= lr[r] * nr_s4[r];
				pl_s5[r] <= lr[r] * lr[r];
				pn_s5[r] <= nr_s4[r] * nr_s4[r];
			end
			d_s6 <= SUM_W'(pd_s5[0]) + SUM_W'(pd_s5[1]) + SUM_W'(pd_s5[2]);
			l2_s6 <= SUM_W'(pl_s5[0]) + SUM_W'(pl_s5[1]) + SUM_W'(pl_s5[2]);
			n2_s6 <= SUM_W'(pn_s5[0]) + SUM_W'(pn_s5[1]) + SUM_W'(pn_s5[2]);
			sq_in_s7 <= l2_s6[SQ_OUT_W-1:0] * n2_s6[SQ_OUT_W-1:0];
			side_s[0].d <= d_s6[CDIV_W-1:0];
			side_s[0].dark <= (d_s6 <= 0) || (l2_s6 == '0) || (n2_s6 == '0);
			side_s[0].base <= base_s6;
			for (int j = 1; j <= SQRT_STAGES; j++) begin
				side_s[j] <= side_s[j-1];
			end
			for (int i = 0; i < 3; i++) begin
				cprod_s40[i] <= CPROD_W'(side_s[SQRT_STAGES].base[i])
					* CPROD_W'(side_s[SQRT_STAGES].d);
			end
			base_s40 <= side_s[SQRT_STAGES].base;
			dark_s40 <= side_s[SQRT_STAGES].dark;
			s_s40 <= root;
			cdiv_s[1] <= cdiv_step(cdiv_init);
			for (int j = 2; j <= COLOR_W; j++) begin
				cdiv_s[j] <= cdiv_step(cdiv_s[j-1]);
			end
			lit_s <= lit_nx;
		end
	end

	assign lit = lit_s;

endmodule

// ----- design/vertex_transform_and_lighting.sv -----
// Vertex transform and diffuse lighting pipeline, top level.
// Latency from an accepted input transaction to its result is set by the 32-stage square
// root and 8-stage colour divider of the lighting path. Throughput is one vertex per cycle
// while in_stall is low; a stalled output is held in a one-entry skid register.
// Asynchronous active-low reset clears the valid bits and loads identity matrices,
// light direction (0, 0, 1) and lighting disabled.
module vertex_transform_and_lighting import vtl_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         in_valid,
	output logic         in_stall,
	input  vertex_in_t   in_data,
	output logic         out_valid,
	input  logic         out_stall,
	output vertex_out_t  out_data
);

	clip_mat_t clip_mat_q;
	norm_mat_t norm_mat_q;
	light_cfg_t light_q;

	logic [LIGHT_DEPTH-1:0] valid_q;
	logic valid_last;
	logic en;
	logic skid_v_q;
	vertex_out_t skid_q;
	vertex_out_t res;
	pos_result_t pos_res;
	logic [2:0][COLOR_W-1:0] lit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_mat_q <= CLIP_RESET;
			norm_mat_q <= NORM_RESET;
			light_q <= LIGHT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CLIP_0: clip_mat_q[0] <= cfg_data;
				REG_CLIP_1: clip_mat_q[1] <= cfg_data;
				REG_CLIP_2: clip_mat_q[2] <= cfg_data;
				REG_CLIP_3: clip_mat_q[3] <= cfg_data;
				REG_NORM_0: norm_mat_q[0] <= cfg_data[47:0];
				REG_NORM_1: norm_mat_q[1] <= cfg_data[47:0];
				REG_NORM_2: norm_mat_q[2] <= cfg_data[47:0];
				REG_LIGHT:  light_q <= cfg_data[48:0];
			endcase
		end
	end

	assign en = !skid_v_q;
	assign in_stall = skid_v_q;
	assign valid_last = valid_q[LIGHT_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[LIGHT_DEPTH-2:0], in_valid};
		end
	end

	vtl_pos_path u_pos (
		.clk      (clk),
		.en       (en),
		.clip_mat (clip_mat_q),
		.vin      (in_data),
		.result   (pos_res)
	);

	vtl_light_path u_light (
		.clk      (clk),
		.en       (en),
		.norm_mat (norm_mat_q),
		.light    (light_q),
		.vin      (in_data),
		.lit      (lit)
	);

	always_comb begin
		res.ndc_x = pos_res.ndc_x;
		res.ndc_y = pos_res.ndc_y;
		res.ndc_z = pos_res.ndc_z;
		res.zero_w = pos_res.zero_w;
		res.lit_red = lit[0];
		res.lit_green = lit[1];
		res.lit_blue = lit[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (!skid_v_q && valid_last && out_stall) begin
			skid_v_q <= 1'b1;
		end else if (skid_v_q && !out_stall) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q && valid_last && out_stall) begin
			skid_q <= res;
		end
	end

	assign out_valid = skid_v_q || valid_last;
	assign out_data = skid_v_q ? skid_q : res;

	a_zero_w_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.zero_w |->
			(out_data.ndc_x == NDC_MAX || out_data.ndc_x == NDC_MIN || out_data.ndc_x == '0))
		else $error("zero w transaction with unsaturated x");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_stall && valid_last))
		else $error("skid register filled without a stalled result");

endmodule
